[rtl/core/bhw_pkg.sv]
`default_nettype none

package bhw_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 4096;

  // Horner cells per series, and the cosine unit latency that follows from them.
  localparam int unsigned HORNER_N = 5;
  localparam int unsigned COS_LAT  = 2 * HORNER_N + 4;

  localparam int unsigned COS_K [HORNER_N] = '{90, 56, 30, 12, 2};
  localparam int unsigned SIN_K [HORNER_N] = '{110, 72, 42, 20, 6};

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

endpackage

`default_nettype wire

[rtl/core/bhw_horner_cell.sv]
`default_nettype none

module bhw_horner_cell
  import bhw_pkg::*;
#(
  parameter int unsigned K = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] x2_in,
  input  logic [30:0] v_in,
  output logic [29:0] x2_out,
  output logic [30:0] v_out
);

  localparam int unsigned SH = 30 + $clog2(K);
  localparam logic [31:0] MAGIC = 32'(((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K));

  logic [29:0] m;
  logic [29:0] x2_a;
  logic [60:0] mp;
  logic [71:0] qp;

  assign mp = 61'(x2_in) * 61'(v_in);
  assign qp = 72'(m) * 72'(MAGIC);

  always_ff @(posedge clk) begin
    if (en) begin
      m      <= mp[59:30];
      x2_a   <= x2_in;
      v_out  <= Q30_ONE - 31'(qp[SH +: 30]);
      x2_out <= x2_a;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bhw_cos.sv]
`default_nettype none

module bhw_cos
  import bhw_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic        [31:0] turn,
  output logic signed [31:0] cos_val
);

  localparam int unsigned DN = 2 * HORNER_N;

  logic [29:0] r;
  logic        mirror;
  logic [29:0] a;
  logic [60:0] xp;
  logic [59:0] x2p;
  logic [60:0] sp;

  logic [29:0] x_s1;
  logic [1:0]  qd_s1;
  logic        mir_s1;
  logic [29:0] x_s2;
  logic [29:0] x2_s2;
  logic [1:0]  qd_s2;
  logic        mir_s2;

  logic [29:0] c_x2 [HORNER_N+1];
  logic [30:0] c_v  [HORNER_N+1];
  logic [29:0] s_x2 [HORNER_N+1];
  logic [30:0] s_v  [HORNER_N+1];

  logic [29:0] x_dly  [DN];
  logic [2:0]  qm_dly [DN+1];

  logic [30:0] c_s13;
  logic [30:0] s_s13;
  logic [30:0] cc;
  logic [30:0] ss;

  assign r      = turn[29:0];
  assign mirror = r > 30'h2000_0000;
  assign a      = mirror ? 30'(31'h4000_0000 - 31'(r)) : r;
  assign xp     = 61'(a) * 61'(HALF_PI_Q30);
  assign x2p    = 60'(x_s1) * 60'(x_s1);

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1   <= xp[59:30];
      qd_s1  <= turn[31:30];
      mir_s1 <= mirror;
      x_s2   <= x_s1;
      x2_s2  <= x2p[59:30];
      qd_s2  <= qd_s1;
      mir_s2 <= mir_s1;
    end
  end

  assign c_x2[0] = x2_s2;
  assign c_v[0]  = Q30_ONE;
  assign s_x2[0] = x2_s2;
  assign s_v[0]  = Q30_ONE;

  for (genvar g = 0; g < HORNER_N; g++) begin : g_cells
    bhw_horner_cell #(.K(COS_K[g])) u_cos_cell (
      .clk    (clk),
      .en     (en),
      .x2_in  (c_x2[g]),
      .v_in   (c_v[g]),
      .x2_out (c_x2[g+1]),
      .v_out  (c_v[g+1])
    );
    bhw_horner_cell #(.K(SIN_K[g])) u_sin_cell (
      .clk    (clk),
      .en     (en),
      .x2_in  (s_x2[g]),
      .v_in   (s_v[g]),
      .x2_out (s_x2[g+1]),
      .v_out  (s_v[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_dly[0]  <= x_s2;
      qm_dly[0] <= {qd_s2, mir_s2};
      for (int i = 1; i < DN; i++) begin
        x_dly[i] <= x_dly[i-1];
      end
      for (int i = 1; i <= DN; i++) begin
        qm_dly[i] <= qm_dly[i-1];
      end
    end
  end

  assign sp = 61'(x_dly[DN-1]) * 61'(s_v[HORNER_N]);

  always_ff @(posedge clk) begin
    if (en) begin
      c_s13 <= c_v[HORNER_N];
      s_s13 <= sp[60:30];
    end
  end

  assign cc = qm_dly[DN][0] ? s_s13 : c_s13;
  assign ss = qm_dly[DN][0] ? c_s13 : s_s13;

  always_ff @(posedge clk) begin
    if (en) begin
      case (qm_dly[DN][2:1])
        2'd0:    cos_val <= 32'(cc);
        2'd1:    cos_val <= 32'd0 - 32'(ss);
        2'd2:    cos_val <= 32'd0 - 32'(cc);
        default: cos_val <= 32'(ss);
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/bhw_div.sv]
`default_nettype none

module bhw_div
  import bhw_pkg::*;
#(
  parameter int unsigned NW = 76,
  parameter int unsigned DW = 43,
  parameter int unsigned QW = 49
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num;
  logic [DW-1:0]    den;
  logic [DW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem, num[NW-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[NW-2:0], 1'b0};
      rem      <= fits ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[rtl/core/blackman_harris_window_generator.sv]
`default_nettype none

// Channel    Direction  Payload                                  Transfer
// s_axis     in         tdata[11:0] coef_index                   tvalid & tready
// m_axis     out        tdata[17:0] coefficient, tuser index_error  tvalid & tready
// cfg        in         cfg_wdata = window_length                 cfg_we
//
// One coefficient is accepted per cycle while s_axis_tready is high, i.e. in the run state with an empty skid.
// The depth is set by the three cosine units (Horner cell rows) and the scaling multipliers.
// After reset or a window_length write the block recomputes the phase step, the window sum
// and the gain, and s_axis_tready stays low until it is done.
// A stalled output holds one extra result in a skid register before the pipeline stops.

module blackman_harris_window_generator
  import bhw_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] coef_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] coefficient
  output logic [0:0]  m_axis_tuser,   // [0] index_error
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned IDX_W = ($clog2(MAX_LENGTH) > 12) ? $clog2(MAX_LENGTH) : 12;
  localparam int unsigned CW    = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int unsigned WW    = (LEN_W > 13) ? LEN_W : 13;
  localparam int unsigned SUM_W = LEN_W + 30;
  localparam int unsigned NW    = LEN_W + 63;
  localparam int unsigned QW    = 49;
  localparam int unsigned ST_COS = 2 + COS_LAT;
  localparam int unsigned ST_H   = ST_COS + 5;
  localparam int unsigned ST_J   = ST_H + 2;

  localparam logic [42:0] RECIP_3125 = 43'(((64'd1 << 54) + 64'd3124) / 64'd3125);
  localparam logic [47:0] GAIN_ONE   = 48'h1_0000_0000;
  localparam logic [17:0] COEF_ONE   = 18'h1_0000;

  typedef enum logic [5:0] {
    ST_SETUP = 6'b000001,
    ST_STEP  = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_GAIN  = 6'b010000,
    ST_RUN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic valid;
    logic sweep;
    logic err;
    logic one;
  } flag_t;

  state_t            state;
  logic [12:0]       window_length;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  eff_comb;
  logic [WW-1:0]     wl_ext;
  logic [39:0]       step;
  logic [47:0]       gain;
  logic [LEN_W-1:0]  sw_idx;
  logic [LEN_W-1:0]  acc_cnt;
  logic [SUM_W-1:0]  sum;

  logic              div_start;
  logic [NW-1:0]     div_dividend;
  logic [SUM_W-1:0]  div_divisor;
  logic              div_done;
  logic [QW-1:0]     div_quo;
  logic [QW-1:0]     gain_rnd;

  logic              en;
  logic              in_xfer;
  logic              sweep_feed;
  logic [IDX_W-1:0]  in_idx;
  logic              in_err;
  logic              drain_done;

  flag_t             flags [ST_J+1];
  logic [IDX_W-1:0]  a_idx;
  logic [39:0]       ph_prod;
  logic [39:0]       ph_sum;
  logic [31:0]       ph;
  logic [31:0]       t1;
  logic [31:0]       t2;
  logic [31:0]       t3;
  logic signed [31:0] c1;
  logic signed [31:0] c2;
  logic signed [31:0] c3;
  logic signed [48:0] p1;
  logic signed [48:0] p2;
  logic signed [48:0] p3;
  logic signed [48:0] r_val;
  logic [46:0]       r_pos;
  logic [47:0]       r_rnd;
  logic [41:0]       y;
  logic [42:0]       pp_hh;
  logic [41:0]       pp_hl;
  logic [42:0]       pp_lh;
  logic [41:0]       pp_ll;
  logic [84:0]       pp_sum;
  logic [30:0]       w30;
  logic [46:0]       g_hi;
  logic [62:0]       g_lo;
  logic [79:0]       v80;
  logic [33:0]       v34;
  logic [17:0]       v_sat;
  logic [17:0]       j_coef;

  logic              pipe_out;
  logic              skid_valid;
  logic [17:0]       skid_coef;
  logic              skid_err;

  assign wl_ext   = WW'(window_length);
  assign eff_comb = (wl_ext == '0) ? LEN_W'(1) :
                    (wl_ext > WW'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : LEN_W'(wl_ext);

  assign en            = !skid_valid;
  assign s_axis_tready = (state == ST_RUN) && en;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign sweep_feed    = (state == ST_SWEEP) && en;
  assign in_idx        = sweep_feed ? IDX_W'(sw_idx) : IDX_W'(s_axis_tdata[11:0]);
  assign in_err        = CW'(in_idx) >= CW'(eff_len);
  assign drain_done    = acc_cnt == eff_len;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = NW'(41'h100_0000_0000 + 41'((eff_comb - LEN_W'(1)) >> 1));
    div_divisor  = SUM_W'(eff_comb - LEN_W'(1));
    unique case (state)
      ST_SETUP: begin
        div_start = eff_comb > LEN_W'(1);
      end
      ST_DRAIN: begin
        div_start    = drain_done && (sum != '0);
        div_dividend = NW'(eff_len) << 63;
        div_divisor  = sum;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bhw_div #(.NW(NW), .DW(SUM_W), .QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign gain_rnd = div_quo + QW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SETUP;
      window_length <= 13'd4096;
    end else if (cfg_we) begin
      state         <= ST_SETUP;
      window_length <= cfg_wdata;
    end else begin
      unique case (state)
        ST_SETUP: begin
          eff_len <= eff_comb;
          if (eff_comb < LEN_W'(2)) begin
            step  <= '0;
            gain  <= GAIN_ONE;
            state <= ST_RUN;
          end else begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (div_done) begin
            step    <= div_quo[39:0];
            sw_idx  <= '0;
            acc_cnt <= '0;
            sum     <= '0;
            state   <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (en) begin
            sw_idx <= sw_idx + LEN_W'(1);
            if (sw_idx == eff_len - LEN_W'(1)) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            if (sum == '0) begin
              gain  <= GAIN_ONE;
              state <= ST_RUN;
            end else begin
              state <= ST_GAIN;
            end
          end
        end
        ST_GAIN: begin
          if (div_done) begin
            gain  <= gain_rnd[48:1];
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_SETUP;
        end
      endcase
      if (en && flags[ST_H].valid && flags[ST_H].sweep) begin
        sum     <= sum + SUM_W'(w30);
        acc_cnt <= acc_cnt + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ST_J; i++) begin
        flags[i] <= '0;
      end
    end else if (en) begin
      flags[0].valid <= in_xfer || sweep_feed;
      flags[0].sweep <= sweep_feed;
      flags[0].err   <= !sweep_feed && in_err;
      flags[0].one   <= eff_len == LEN_W'(1);
      for (int i = 1; i <= ST_J; i++) begin
        flags[i] <= flags[i-1];
      end
    end
  end

  assign ph_prod = 40'(a_idx) * step;
  assign ph_sum  = ph_prod + 40'd128;

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx <= in_idx;
      ph    <= ph_sum[39:8];
      t1    <= ph;
      t2    <= {ph[30:0], 1'b0};
      t3    <= ph + {ph[30:0], 1'b0};
    end
  end

  bhw_cos u_cos1 (.clk(clk), .en(en), .turn(t1), .cos_val(c1));
  bhw_cos u_cos2 (.clk(clk), .en(en), .turn(t2), .cos_val(c2));
  bhw_cos u_cos3 (.clk(clk), .en(en), .turn(t3), .cos_val(c3));

  assign r_pos  = r_val[48] ? '0 : r_val[46:0];
  assign r_rnd  = 48'(r_pos) + 48'd50000;
  assign pp_sum = (85'(pp_hh) << 42) + ((85'(pp_hl) + 85'(pp_lh)) << 21) + 85'(pp_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= $signed({{17{c1[31]}}, c1}) * 49'sd48829;
      p2    <= $signed({{17{c2[31]}}, c2}) * 49'sd14128;
      p3    <= $signed({{17{c3[31]}}, c3}) * 49'sd1168;
      r_val <= (49'sd35875 <<< 30) - p1 + p2 - p3;
      y     <= r_rnd[46:5];
      pp_hh <= 43'(y[41:21]) * 43'(RECIP_3125[42:21]);
      pp_hl <= 42'(y[41:21]) * 42'(RECIP_3125[20:0]);
      pp_lh <= 43'(y[20:0]) * 43'(RECIP_3125[42:21]);
      pp_ll <= 42'(y[20:0]) * 42'(RECIP_3125[20:0]);
      w30   <= pp_sum[84:54];
      g_hi  <= 47'(w30) * 47'(gain[47:32]);
      g_lo  <= 63'(w30) * 63'(gain[31:0]);
    end
  end

  assign v80   = 80'({g_hi, 32'd0}) + 80'(g_lo) + (80'd1 << 45);
  assign v34   = v80[79:46];
  assign v_sat = (v34[33:18] != '0) ? 18'h3FFFF : v34[17:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (flags[ST_H+1].err) begin
        j_coef <= '0;
      end else if (flags[ST_H+1].one) begin
        j_coef <= COEF_ONE;
      end else begin
        j_coef <= v_sat;
      end
    end
  end

  assign pipe_out = flags[ST_J].valid && !flags[ST_J].sweep;

  // The output register takes the last stage when free; a stalled transfer parks it in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (en) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= pipe_out;
      end else if (pipe_out) begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tdata    <= {6'd0, j_coef};
        m_axis_tuser[0] <= flags[ST_J].err;
      end else begin
        skid_coef <= j_coef;
        skid_err  <= flags[ST_J].err;
      end
    end else if (m_axis_tready) begin
      m_axis_tdata    <= {6'd0, skid_coef};
      m_axis_tuser[0] <= skid_err;
    end
  end

endmodule

`default_nettype wire
